// ----- rtl/assert_macros.svh -----
// Assertion macros for the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked at every rising edge of clk, including while reset is asserted.
`define ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);

// Checked at every rising edge of clk while rst_n is high.
`define ASSERT_RUN(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

`endif

// ----- rtl/skt_pkg.sv -----
// Types and constants for the sorted key table.
package skt_pkg;

    localparam int DEF_MAX_ENTRIES   = 64;
    localparam int DEF_PAYLOAD_WIDTH = 64;

    localparam int KEY_W       = 32;
    localparam int PAY_PORT_W  = 64;
    localparam int TOTAL_W     = 7;
    localparam int IN_TDATA_W  = 104;
    localparam int OUT_TDATA_W = 80;

    localparam logic [1:0] MODE_INSERT = 2'd0;
    localparam logic [1:0] MODE_SEARCH = 2'd1;
    localparam logic [1:0] MODE_DELETE = 2'd2;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_DUP     = 2'd1,
        ST_FULL    = 2'd2,
        ST_MISSING = 2'd3
    } status_t;

endpackage

// ----- rtl/sorted_key_table.sv -----
// Sorted key table: keeps up to MAX_ENTRIES records in ascending key order in a single
// record memory (one write and one registered read port) and serves one insert, search
// or delete at a time. An operation runs a binary search, where each probe reads the
// middle record and then compares its key, then moves records one at a time through
// the single memory port (count-pos moves for an insert, count-pos-1 for a delete)
// and writes the last of them, then finishes and places its result. A new beat is
// taken only when the previous operation has placed its result in the output register.
// The memory needs no clearing after reset: only entries below the record count are
// ever read.
module sorted_key_table
    import skt_pkg::*;
#(
    parameter int MAX_ENTRIES   = DEF_MAX_ENTRIES,
    parameter int PAYLOAD_WIDTH = DEF_PAYLOAD_WIDTH
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    // mode [1:0], key [33:2], payload [97:34], zero fill [103:98]
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // status [1:0], found [2], read_payload [66:3], entry_total [73:67], zero fill [79:74]
    output logic [OUT_TDATA_W-1:0] m_axis_tdata
);

    `include "assert_macros.svh"

    localparam int IDX_W = $clog2(MAX_ENTRIES);
    localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
    localparam int REC_W = KEY_W + PAYLOAD_WIDTH;

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_PROBE = 7'b0000010,
        S_CMP   = 7'b0000100,
        S_MOVE  = 7'b0001000,
        S_FIN   = 7'b0010000,
        S_DONE  = 7'b0100000,
        S_SPARE = 7'b1000000
    } state_t;

    state_t                   state_reg, state_next;
    logic [1:0]               mode_reg, mode_next;
    logic [KEY_W-1:0]         key_reg, key_next;
    logic [PAYLOAD_WIDTH-1:0] pay_reg, pay_next;
    logic [CNT_W-1:0]         count_reg, count_next;
    logic [CNT_W-1:0]         lo_reg, lo_next;
    logic [CNT_W-1:0]         hi_reg, hi_next;
    logic [CNT_W-1:0]         mid_reg, mid_next;
    logic [CNT_W-1:0]         pos_reg, pos_next;
    logic [CNT_W-1:0]         rem_reg, rem_next;
    logic [IDX_W-1:0]         src_reg, src_next;
    logic [IDX_W-1:0]         dst_reg, dst_next;
    logic                     pend_reg, pend_next;
    status_t                  status_reg, status_next;
    logic                     found_reg, found_next;
    logic [PAYLOAD_WIDTH-1:0] rpay_reg, rpay_next;

    logic                     out_valid_reg;
    logic [OUT_TDATA_W-1:0]   out_data_reg;
    logic                     out_load;

    logic [REC_W-1:0]         rec_mem [MAX_ENTRIES];
    logic [REC_W-1:0]         mem_rdata_reg;
    logic                     mem_we, mem_re;
    logic [IDX_W-1:0]         mem_waddr, mem_raddr;
    logic [REC_W-1:0]         mem_wdata;

    logic [CNT_W-1:0]         mid;
    logic [KEY_W-1:0]         rd_key;
    logic [CNT_W+TOTAL_W-1:0] total_ext;
    logic [PAYLOAD_WIDTH+PAY_PORT_W-1:0] rpay_ext;
    logic                     hit;
    logic [CNT_W-1:0]         hit_pos;
    logic [CNT_W-1:0]         last_idx;
    logic [CNT_W-1:0]         mid_inc;

    assign s_axis_tready = (state_reg == S_IDLE);
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    assign mid    = lo_reg + ((hi_reg - lo_reg) >> 1);
    assign rd_key = mem_rdata_reg[REC_W-1:PAYLOAD_WIDTH];

    // Highest held entry, and the entry just above a match.
    assign last_idx = count_reg - CNT_W'(1);
    assign mid_inc  = mid_reg + CNT_W'(1);

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            rec_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            mem_rdata_reg <= rec_mem[mem_raddr];
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        mode_next   = mode_reg;
        key_next    = key_reg;
        pay_next    = pay_reg;
        count_next  = count_reg;
        lo_next     = lo_reg;
        hi_next     = hi_reg;
        mid_next    = mid_reg;
        pos_next    = pos_reg;
        rem_next    = rem_reg;
        src_next    = src_reg;
        dst_next    = dst_reg;
        pend_next   = pend_reg;
        status_next = status_reg;
        found_next  = found_reg;
        rpay_next   = rpay_reg;
        mem_we      = 1'b0;
        mem_re      = 1'b0;
        mem_waddr   = dst_reg;
        mem_raddr   = src_reg;
        mem_wdata   = mem_rdata_reg;
        out_load    = 1'b0;
        hit         = 1'b0;
        hit_pos     = lo_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    mode_next   = s_axis_tdata[1:0];
                    key_next    = s_axis_tdata[33:2];
                    pay_next    = s_axis_tdata[34 +: PAYLOAD_WIDTH];
                    lo_next     = '0;
                    hi_next     = count_reg;
                    status_next = ST_OK;
                    found_next  = 1'b0;
                    rpay_next   = '0;
                    pend_next   = 1'b0;
                    if (s_axis_tdata[1:0] == MODE_INSERT
                        && count_reg >= CNT_W'(MAX_ENTRIES))
                    begin
                        status_next = ST_FULL;
                        state_next  = S_DONE;
                    end
                    else if (s_axis_tdata[1:0] == MODE_INSERT
                             || s_axis_tdata[1:0] == MODE_SEARCH
                             || s_axis_tdata[1:0] == MODE_DELETE)
                    begin
                        state_next = S_PROBE;
                    end
                    else
                    begin
                        state_next = S_DONE;
                    end
                end
            end
            S_PROBE:
            begin
                if (lo_reg < hi_reg)
                begin
                    mem_re     = 1'b1;
                    mem_raddr  = mid[IDX_W-1:0];
                    mid_next   = mid;
                    state_next = S_CMP;
                end
                else
                begin
                    hit_pos = lo_reg;
                end
            end
            S_CMP:
            begin
                if (rd_key == key_reg)
                begin
                    hit     = 1'b1;
                    hit_pos = mid_reg;
                end
                else
                begin
                    if (rd_key < key_reg)
                    begin
                        lo_next = mid_reg + CNT_W'(1);
                    end
                    else
                    begin
                        hi_next = mid_reg;
                    end
                    state_next = S_PROBE;
                end
            end
            S_MOVE:
            begin
                // The write lands two entries away from the read, so the ports never clash.
                mem_we    = pend_reg;
                mem_waddr = dst_reg;
                mem_wdata = mem_rdata_reg;
                if (rem_reg != '0)
                begin
                    mem_re    = 1'b1;
                    mem_raddr = src_reg;
                    pend_next = 1'b1;
                    rem_next  = rem_reg - CNT_W'(1);
                    if (mode_reg == MODE_INSERT)
                    begin
                        dst_next = src_reg + IDX_W'(1);
                        src_next = src_reg - IDX_W'(1);
                    end
                    else
                    begin
                        dst_next = src_reg - IDX_W'(1);
                        src_next = src_reg + IDX_W'(1);
                    end
                end
                else
                begin
                    pend_next  = 1'b0;
                    state_next = S_FIN;
                end
            end
            S_FIN:
            begin
                if (mode_reg == MODE_INSERT)
                begin
                    mem_we     = 1'b1;
                    mem_waddr  = pos_reg[IDX_W-1:0];
                    mem_wdata  = {key_reg, pay_reg};
                    count_next = count_reg + CNT_W'(1);
                end
                else
                begin
                    count_next = count_reg - CNT_W'(1);
                end
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (!out_valid_reg || m_axis_tready)
                begin
                    out_load   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // Outcome of the search, taken either on a match or when the range is empty.
        if ((state_reg == S_CMP && rd_key == key_reg)
            || (state_reg == S_PROBE && !(lo_reg < hi_reg)))
        begin
            pos_next = hit_pos;
            priority case (mode_reg)
                MODE_INSERT:
                begin
                    if (hit)
                    begin
                        status_next = ST_DUP;
                        state_next  = S_DONE;
                    end
                    else
                    begin
                        rem_next   = count_reg - hit_pos;
                        src_next   = last_idx[IDX_W-1:0];
                        state_next = S_MOVE;
                    end
                end
                MODE_SEARCH:
                begin
                    if (hit)
                    begin
                        found_next = 1'b1;
                        rpay_next  = mem_rdata_reg[PAYLOAD_WIDTH-1:0];
                    end
                    else
                    begin
                        status_next = ST_MISSING;
                    end
                    state_next = S_DONE;
                end
                default:
                begin
                    if (hit)
                    begin
                        // A match only comes from the compare step, so the slot is mid_reg.
                        rem_next   = count_reg - hit_pos - CNT_W'(1);
                        src_next   = mid_inc[IDX_W-1:0];
                        state_next = S_MOVE;
                    end
                    else
                    begin
                        status_next = ST_MISSING;
                        state_next  = S_DONE;
                    end
                end
            endcase
        end
    end

    assign total_ext = {{TOTAL_W{1'b0}}, count_reg};
    assign rpay_ext  = {{PAY_PORT_W{1'b0}}, rpay_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            pend_reg  <= pend_next;
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        mode_reg   <= mode_next;
        key_reg    <= key_next;
        pay_reg    <= pay_next;
        lo_reg     <= lo_next;
        hi_reg     <= hi_next;
        mid_reg    <= mid_next;
        pos_reg    <= pos_next;
        rem_reg    <= rem_next;
        src_reg    <= src_next;
        dst_reg    <= dst_next;
        status_reg <= status_next;
        found_reg  <= found_next;
        rpay_reg   <= rpay_next;
        if (out_load)
        begin
            out_data_reg <= {{(OUT_TDATA_W - 74){1'b0}}, total_ext[TOTAL_W-1:0],
                             rpay_ext[PAY_PORT_W-1:0], found_reg, status_reg};
        end
    end

    `ASSERT_RUN(a_count_bound, count_reg <= CNT_W'(MAX_ENTRIES),
                "record count exceeds the table depth")
    `ASSERT_RUN(a_port_clash, (mem_we && mem_re) |-> (mem_waddr != mem_raddr),
                "memory read and write hit the same entry in one cycle")
    `ASSERT_RUN(a_result_source, $rose(m_axis_tvalid) |-> $past(state_reg == S_DONE),
                "result beat raised outside the completion step")
    `ASSERT_RUN(a_count_update, (count_reg != $past(count_reg)) |-> $past(state_reg == S_FIN),
                "record count changed outside the finishing step")

endmodule

// ----- tb/testbench.sv -----
`timescale 1ns / 1ps
// Self-checking sorted key table testbench: directed and random ops checked by typed rows or a predictor.
module testbench;
    import skt_pkg::*;

    localparam int         DEPTH       = DEF_MAX_ENTRIES;
    localparam int         RANDOM_OPS  = 1900;
    localparam logic [1:0] MODE_UNUSED = 2'd3;

    typedef struct packed {
        status_t     status;
        logic        found;
        logic [63:0] read_payload;
        logic [6:0]  entry_total;
    } result_t;

    typedef struct packed {
        logic [1:0]  mode;
        logic [31:0] key;
        logic [63:0] pay;
        bit          typed;
        result_t     want;
    } op_row_t;

    typedef enum {PH_FILL, PH_DRAIN, PH_MIXED} phase_t;

    localparam result_t NO_CHECK = '{ST_OK, 1'b0, 64'h0, 7'd0};

    // Rows with typed results are those whose outcome is obvious; the rest go to the predictor.
    localparam op_row_t DIRECTED_OPS [0:22] = '{
        '{MODE_SEARCH, 32'h1234_5678, 64'h0, 1'b1, '{ST_MISSING, 1'b0, 64'h0, 7'd0}},
        '{MODE_DELETE, 32'h0000_0000, 64'h0, 1'b1, '{ST_MISSING, 1'b0, 64'h0, 7'd0}},
        '{MODE_UNUSED, 32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1,
          '{ST_OK, 1'b0, 64'h0, 7'd0}},
        '{MODE_INSERT, 32'h0000_0000, 64'h0, 1'b1, '{ST_OK, 1'b0, 64'h0, 7'd1}},
        '{MODE_INSERT, 32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1,
          '{ST_OK, 1'b0, 64'h0, 7'd2}},
        '{MODE_INSERT, 32'h0000_0000, 64'h5, 1'b1, '{ST_DUP, 1'b0, 64'h0, 7'd2}},
        '{MODE_SEARCH, 32'h0000_0000, 64'h0, 1'b1, '{ST_OK, 1'b1, 64'h0, 7'd2}},
        '{MODE_SEARCH, 32'hFFFF_FFFF, 64'h0, 1'b1,
          '{ST_OK, 1'b1, 64'hFFFF_FFFF_FFFF_FFFF, 7'd2}},
        '{MODE_INSERT, 32'h8000_0000, 64'hA5A5_A5A5_A5A5_A5A5, 1'b1,
          '{ST_OK, 1'b0, 64'h0, 7'd3}},
        '{MODE_INSERT, 32'h7FFF_FFFF, 64'h5A5A_5A5A_5A5A_5A5A, 1'b0, NO_CHECK},
        '{MODE_INSERT, 32'h0000_0001, 64'h0123_4567_89AB_CDEF, 1'b0, NO_CHECK},
        '{MODE_SEARCH, 32'h7FFF_FFFF, 64'h0, 1'b0, NO_CHECK},
        '{MODE_SEARCH, 32'h7FFF_FFFE, 64'h0, 1'b0, NO_CHECK},
        '{MODE_DELETE, 32'h8000_0000, 64'h0, 1'b0, NO_CHECK},
        '{MODE_SEARCH, 32'h8000_0000, 64'h0, 1'b0, NO_CHECK},
        '{MODE_DELETE, 32'h8000_0000, 64'h0, 1'b1, '{ST_MISSING, 1'b0, 64'h0, 7'd4}},
        '{MODE_UNUSED, 32'h0000_0000, 64'h0, 1'b1, '{ST_OK, 1'b0, 64'h0, 7'd4}},
        '{MODE_DELETE, 32'h0000_0000, 64'h0, 1'b0, NO_CHECK},
        '{MODE_DELETE, 32'hFFFF_FFFF, 64'h0, 1'b0, NO_CHECK},
        '{MODE_SEARCH, 32'h0000_0001, 64'h0, 1'b0, NO_CHECK},
        '{MODE_DELETE, 32'h0000_0001, 64'h0, 1'b0, NO_CHECK},
        '{MODE_DELETE, 32'h7FFF_FFFF, 64'h0, 1'b0, NO_CHECK},
        '{MODE_SEARCH, 32'h0000_0000, 64'h0, 1'b1, '{ST_MISSING, 1'b0, 64'h0, 7'd0}}
    };

    logic                   clk;
    logic                   rst_n         = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata  = '0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;

    // Predictor state: the records in ascending key order.
    logic [31:0] held_keys [0:DEPTH-1];
    logic [63:0] held_pays [0:DEPTH-1];
    int          held_count = 0;

    result_t     pending_results [$];
    int          beats_sent   = 0;
    int          results_seen = 0;
    int          fault_count  = 0;

    sorted_key_table u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        #25_000_000;
        $display("[sorted_key_table] ERROR");
        $finish;
    end

    // Returns whether the key is held; slot gets the match or the insertion point.
    function automatic bit locate_key(input logic [31:0] key, output int slot);
        int lo;
        int hi;
        int mid;
        lo = 0;
        hi = held_count;
        while (lo < hi)
        begin
            mid = lo + (hi - lo) / 2;
            if (held_keys[mid] == key)
            begin
                slot = mid;
                return 1'b1;
            end
            if (held_keys[mid] < key)
                lo = mid + 1;
            else
                hi = mid;
        end
        slot = lo;
        return 1'b0;
    endfunction

    function automatic result_t apply_table_op(input logic [1:0] mode, input logic [31:0] key,
                                               input logic [63:0] pay);
        result_t res;
        int      slot;
        bit      hit;
        res = NO_CHECK;
        hit = locate_key(key, slot);
        case (mode)
            MODE_INSERT:
            begin
                if (held_count >= DEPTH)
                    res.status = ST_FULL;
                else if (hit)
                    res.status = ST_DUP;
                else
                begin
                    for (int i = held_count; i > slot; i--)
                    begin
                        held_keys[i] = held_keys[i-1];
                        held_pays[i] = held_pays[i-1];
                    end
                    held_keys[slot] = key;
                    held_pays[slot] = pay;
                    held_count++;
                end
            end
            MODE_SEARCH:
            begin
                if (hit)
                begin
                    res.found        = 1'b1;
                    res.read_payload = held_pays[slot];
                end
                else
                    res.status = ST_MISSING;
            end
            MODE_DELETE:
            begin
                if (hit)
                begin
                    for (int i = slot; i + 1 < held_count; i++)
                    begin
                        held_keys[i] = held_keys[i+1];
                        held_pays[i] = held_pays[i+1];
                    end
                    held_count--;
                end
                else
                    res.status = ST_MISSING;
            end
            default: ;
        endcase
        res.entry_total = held_count[6:0];
        return res;
    endfunction

    // Offers one beat after a random gap and records the expected result once it is taken.
    task automatic send_op(input logic [1:0] mode, input logic [31:0] key,
                           input logic [63:0] pay, input bit typed, input result_t want);
        int      gap;
        int      r;
        result_t predicted;
        gap = 0;
        r   = $urandom_range(0, 99);
        if ((beats_sent % 300) < 240)
        begin
            if (r >= 97)
                gap = $urandom_range(20, 100);
            else if (r >= 88)
                gap = $urandom_range(4, 15);
            else if (r >= 60)
                gap = $urandom_range(1, 3);
        end
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {6'b0, pay, key, mode};
        do @(posedge clk); while (!s_axis_tready);
        beats_sent++;
        predicted = apply_table_op(mode, key, pay);
        pending_results.push_back(typed ? want : predicted);
    endtask

    // Result side: checks each accepted beat and drives tready with random stalls.
    initial
    begin
        result_t got;
        result_t want;
        int      stall_left;
        int      cycle_count;
        bit      hold_done;
        stall_left  = 0;
        cycle_count = 0;
        hold_done   = 1'b0;
        forever
        begin
            @(posedge clk);
            cycle_count++;
            if (rst_n && m_axis_tvalid && m_axis_tready)
            begin
                results_seen++;
                got.status       = status_t'(m_axis_tdata[1:0]);
                got.found        = m_axis_tdata[2];
                got.read_payload = m_axis_tdata[66:3];
                got.entry_total  = m_axis_tdata[73:67];
                if (pending_results.size() == 0)
                begin
                    fault_count++;
                    if (fault_count <= 10)
                        $display("result beat %0d arrived with nothing expected", results_seen);
                end
                else
                begin
                    want = pending_results.pop_front();
                    if (got.status !== want.status || got.found !== want.found ||
                        got.read_payload !== want.read_payload ||
                        got.entry_total !== want.entry_total)
                    begin
                        fault_count++;
                        if (fault_count <= 10)
                        begin
                            $display("result %0d: expected status %0d found %0d payload %h total %0d",
                                     results_seen, want.status, want.found, want.read_payload,
                                     want.entry_total);
                            $display("result %0d: got status %0d found %0d payload %h total %0d",
                                     results_seen, got.status, got.found, got.read_payload,
                                     got.entry_total);
                        end
                    end
                end
            end
            if (stall_left > 0)
            begin
                stall_left--;
                m_axis_tready <= 1'b0;
            end
            else if (!hold_done && results_seen >= 400)
            begin
                // A long hold-off so that the block backs up and refuses input beats.
                hold_done     = 1'b1;
                stall_left    = 3000;
                m_axis_tready <= 1'b0;
            end
            else if ((cycle_count % 20000) >= 3000 && $urandom_range(0, 99) < 25)
            begin
                stall_left    = ($urandom_range(0, 99) < 90) ? $urandom_range(1, 4)
                                                             : $urandom_range(20, 80);
                m_axis_tready <= 1'b0;
            end
            else
                m_axis_tready <= 1'b1;
        end
    end

    initial
    begin
        phase_t      phase;
        int          full_refusals;
        int          mixed_left;
        int          r;
        int          waited;
        int          exist_pct;
        logic [1:0]  mode;
        logic [31:0] key;
        logic [63:0] pay;
        phase         = PH_FILL;
        full_refusals = 0;
        mixed_left    = 0;
        waited        = 0;

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (DIRECTED_OPS[i])
            send_op(DIRECTED_OPS[i].mode, DIRECTED_OPS[i].key, DIRECTED_OPS[i].pay,
                    DIRECTED_OPS[i].typed, DIRECTED_OPS[i].want);

        // Fill the table until inserts are refused, drain it, and now and then churn a
        // narrow key range so that duplicates and hits are frequent.
        for (int n = 0; n < RANDOM_OPS; n++)
        begin
            r = $urandom_range(0, 99);
            case (phase)
                PH_FILL:  mode = (r < 70) ? MODE_INSERT : (r < 85) ? MODE_SEARCH :
                                 (r < 97) ? MODE_DELETE : MODE_UNUSED;
                PH_DRAIN: mode = (r < 10) ? MODE_INSERT : (r < 30) ? MODE_SEARCH :
                                 (r < 97) ? MODE_DELETE : MODE_UNUSED;
                default:  mode = (r < 32) ? MODE_INSERT : (r < 64) ? MODE_SEARCH :
                                 (r < 97) ? MODE_DELETE : MODE_UNUSED;
            endcase

            r         = $urandom_range(0, 99);
            exist_pct = (phase == PH_DRAIN) ? 75 : 45;
            if (phase == PH_MIXED && r < 85)
                key = $urandom_range(0, 31);
            else if (held_count > 0 && r < exist_pct)
                key = held_keys[$urandom_range(0, held_count - 1)];
            else if (held_count > 0 && r < exist_pct + 15)
                key = held_keys[$urandom_range(0, held_count - 1)] +
                      (($urandom_range(0, 1) == 1) ? 32'd1 : 32'hFFFF_FFFF);
            else if (r < exist_pct + 23)
                case ($urandom_range(0, 3))
                    0:       key = 32'h0000_0000;
                    1:       key = 32'hFFFF_FFFF;
                    2:       key = 32'h7FFF_FFFF;
                    default: key = 32'h8000_0000;
                endcase
            else
                key = $urandom;

            r = $urandom_range(0, 9);
            if (r == 0)
                pay = 64'h0;
            else if (r == 1)
                pay = 64'hFFFF_FFFF_FFFF_FFFF;
            else
                pay = {$urandom, $urandom};

            send_op(mode, key, pay, 1'b0, NO_CHECK);

            case (phase)
                PH_FILL:
                begin
                    if (mode == MODE_INSERT && held_count == DEPTH)
                        full_refusals++;
                    if (full_refusals >= 4)
                    begin
                        full_refusals = 0;
                        phase         = PH_DRAIN;
                    end
                end
                PH_DRAIN:
                begin
                    if (held_count == 0)
                    begin
                        if ($urandom_range(0, 2) == 0)
                        begin
                            phase      = PH_MIXED;
                            mixed_left = 120;
                        end
                        else
                            phase = PH_FILL;
                    end
                end
                default:
                begin
                    mixed_left--;
                    if (mixed_left <= 0)
                        phase = PH_FILL;
                end
            endcase
        end
        s_axis_tvalid <= 1'b0;

        while (pending_results.size() != 0 && waited < 200000)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (200) @(posedge clk);
        if (pending_results.size() != 0)
        begin
            fault_count++;
            $display("%0d expected results never arrived", pending_results.size());
        end
        if (fault_count == 0)
            $display("[sorted_key_table] OK");
        else
            $display("[sorted_key_table] ERROR");
        $finish;
    end

endmodule

// ----- sim.f -----
+incdir+rtl
rtl/skt_pkg.sv
rtl/sorted_key_table.sv
tb/testbench.sv
